/* hdl/fde_pkg.sv */
`default_nettype none
package fde_pkg;

  // Field widths.
  localparam int SAMPLE_W   = 24;
  localparam int DMS_W      = 11;
  localparam int GAIN_W     = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Default configuration of the delay line.
  localparam int DEF_AUDIO_FS          = 48000;
  localparam int DEF_MAX_DELAY_SECONDS = 2;

  localparam int MS_PER_SECOND = 1000;
  // Width of the remainder AUDIO_FS % MS_PER_SECOND.
  localparam int REM_W         = 10;

  // Exact division by MS_PER_SECOND of any value below 2**(DMS_W + REM_W).
  localparam int          RECIP_K = 41;
  localparam logic [31:0] RECIP_M =
    32'(((64'd1 << RECIP_K) + 64'(MS_PER_SECOND) - 64'd1) / 64'(MS_PER_SECOND));

  // Q1.16 feedback gain.
  localparam int GAIN_FRAC  = 16;
  localparam int GAIN_ONE   = 65536;
  localparam int ROUND_HALF = GAIN_ONE / 2;

  localparam logic [DMS_W-1:0]  DELAY_MS_RESET = DMS_W'(500);
  localparam logic [GAIN_W-1:0] GAIN_RESET     = GAIN_W'(32768);

  // Cycles from a delay write until the sample delay is ready.
  localparam int DSAMP_LAT = 3;

  // Output queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = 2;

  // Width of the sums before saturation.
  localparam int SAT_W = SAMPLE_W + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_MS      = 1'b0,
    CFG_FEEDBACK_GAIN = 1'b1
  } cfg_reg_t;

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}));
    lo = SAT_W'(signed'({1'b1, {(SAMPLE_W-1){1'b0}}}));
    if (v > hi) begin
      sat24 = hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      sat24 = lo[SAMPLE_W-1:0];
    end else begin
      sat24 = v[SAMPLE_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* hdl/feedback_delay_echo.sv */
`default_nettype none
// Feedback echo over a circular delay memory of AUDIO_FS * MAX_DELAY_SECONDS
// samples. Each beat on the input gives one beat on the output, in order; a
// taken sample goes through stage one into the output queue, from which it
// is offered on out_sample. The block takes one sample per cycle while the
// output queue has room, set by the single read and single write port of
// the delay memory; when the delay is one or two samples the read may have
// to wait until the write of an earlier sample leaves the middle stages, and
// the rate falls. After reset and after every write of delay_ms the input is
// stalled while the delay in samples is worked out. The memory is not swept
// after reset: entries that the write pointer has not yet reached read as
// zero. A delay of zero, or one longer than the memory, gives the full
// memory length. A four-beat output queue lets the input run on while results
// wait to be taken.
module feedback_delay_echo #(
  parameter int AUDIO_FS          = fde_pkg::DEF_AUDIO_FS,
  parameter int MAX_DELAY_SECONDS = fde_pkg::DEF_MAX_DELAY_SECONDS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [fde_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [fde_pkg::SAMPLE_W-1:0]        out_sample,
  input  wire logic                                  cfg_we,
  input  wire logic [fde_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [fde_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int SW     = fde_pkg::SAMPLE_W;
  localparam int DEPTH  = AUDIO_FS * MAX_DELAY_SECONDS;
  localparam int AW     = $clog2(DEPTH);
  localparam int Q      = AUDIO_FS / fde_pkg::MS_PER_SECOND;
  localparam int R      = AUDIO_FS % fde_pkg::MS_PER_SECOND;
  localparam int QW     = $clog2(Q + 1);
  localparam int FRAC_W = fde_pkg::DMS_W + fde_pkg::REM_W;
  localparam int BASE_W = fde_pkg::DMS_W + QW;
  localparam int RAW_W  = BASE_W + 1;
  localparam int CMP_W  = (RAW_W > AW + 1) ? RAW_W : AW + 1;
  localparam int PROD_W = SW + fde_pkg::GAIN_W + 1;
  localparam int SCL_W  = PROD_W - fde_pkg::GAIN_FRAC;
  localparam int SAT_W  = fde_pkg::SAT_W;
  localparam int FPW    = fde_pkg::FIFO_PW;
  localparam int CNT_W  = FPW + 1;

  localparam logic [AW:0]                   DEPTH_C = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0]                 LAST_C  = AW'(DEPTH - 1);
  localparam logic [QW-1:0]                 Q_C     = QW'(Q);
  localparam logic [fde_pkg::REM_W-1:0]     R_C     = fde_pkg::REM_W'(R);
  localparam logic [fde_pkg::GAIN_W-1:0]    GMAX_C  = fde_pkg::GAIN_W'(fde_pkg::GAIN_ONE);
  localparam logic [1:0]                    LAT_C   = 2'(fde_pkg::DSAMP_LAT);

  // Configuration.
  logic [fde_pkg::DMS_W-1:0]  delay_ms_r;
  logic [fde_pkg::GAIN_W-1:0] gain_r;
  logic [1:0]                 dly_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_ms_r <= fde_pkg::DELAY_MS_RESET;
      gain_r     <= fde_pkg::GAIN_RESET;
      dly_cnt_r  <= LAT_C;
    end else begin
      if (dly_cnt_r != 2'd0) begin
        dly_cnt_r <= dly_cnt_r - 2'd1;
      end
      if (cfg_we) begin
        case (fde_pkg::cfg_reg_t'(cfg_index))
          fde_pkg::CFG_DELAY_MS: begin
            delay_ms_r <= cfg_data[fde_pkg::DMS_W-1:0];
            dly_cnt_r  <= LAT_C;
          end
          fde_pkg::CFG_FEEDBACK_GAIN: begin
            gain_r <= (cfg_data > GMAX_C) ? GMAX_C : cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Delay in samples: delay_ms * Q plus floor(delay_ms * R / 1000), the latter
  // through a reciprocal multiply. The result is kept as DEPTH - delay.
  logic [BASE_W-1:0]            base1_r, base2_r;
  logic [FRAC_W-1:0]            frac1_r;
  logic [fde_pkg::DMS_W-1:0]    quo2_r;
  logic [FRAC_W+31:0]           quo_full;
  logic [CMP_W-1:0]             raw_dsamp;
  logic [AW:0]                  dsamp_sat;
  logic [AW:0]                  off_r;

  assign quo_full  = (FRAC_W + 32)'(frac1_r) * (FRAC_W + 32)'(fde_pkg::RECIP_M);
  assign raw_dsamp = CMP_W'(base2_r) + CMP_W'(quo2_r);
  assign dsamp_sat = (raw_dsamp > CMP_W'(DEPTH_C)) ? DEPTH_C : raw_dsamp[AW:0];

  always_ff @(posedge clk) begin
    base1_r <= BASE_W'(delay_ms_r) * BASE_W'(Q_C);
    frac1_r <= FRAC_W'(delay_ms_r) * FRAC_W'(R_C);
    base2_r <= base1_r;
    quo2_r  <= quo_full[fde_pkg::RECIP_K + fde_pkg::DMS_W - 1 : fde_pkg::RECIP_K];
    off_r   <= DEPTH_C - dsamp_sat;
  end

  // Read address and hazard check.
  logic [AW-1:0] wp_r;
  logic          wrapped_r;
  logic [AW:0]   rd_sum;
  logic [AW-1:0] rd_addr;
  logic          rd_live;
  logic          hazard;
  logic          accept;

  logic                  s1_valid_r, s1_live_r, s1_fwd_r;
  logic signed [SW-1:0]  s1_x_r, s1_fwd_d_r;
  logic [AW-1:0]         s1_wp_r;
  logic                  s2_valid_r;
  logic signed [SW-1:0]  s2_x_r;
  logic [AW-1:0]         s2_wp_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic                  s3_valid_r;
  logic signed [SW-1:0]  s3_w_r;
  logic [AW-1:0]         s3_wp_r;

  logic [CNT_W-1:0]      q_cnt_r;
  logic                  pop;

  assign rd_sum  = {1'b0, wp_r} + off_r;
  assign rd_addr = (rd_sum >= DEPTH_C) ? AW'(rd_sum - DEPTH_C) : rd_sum[AW-1:0];
  assign rd_live = wrapped_r || (rd_addr < wp_r);
  // Entries still being computed in the middle stages cannot be forwarded.
  assign hazard  = (s1_valid_r && (s1_wp_r == rd_addr)) ||
                   (s2_valid_r && (s2_wp_r == rd_addr));
  assign in_stall = (dly_cnt_r != 2'd0) || hazard ||
                    ((CNT_W + 1)'(q_cnt_r) + (CNT_W + 1)'(s1_valid_r) >=
                     (CNT_W + 1)'(fde_pkg::FIFO_DEPTH));
  assign accept   = in_valid && !in_stall;

  // Delay memory.
  logic signed [SW-1:0] dmem [DEPTH];
  logic signed [SW-1:0] mem_q_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q_r <= dmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid_r) begin
      dmem[s3_wp_r] <= s3_w_r;
    end
  end

  // Stage one: delayed sample, output sum and feedback product.
  logic signed [SW-1:0]     delayed;
  logic signed [SAT_W-1:0]  y_sum;
  logic signed [SW-1:0]     y_nxt;
  logic signed [PROD_W-1:0] prod_nxt;

  assign delayed  = s1_fwd_r ? s1_fwd_d_r : (s1_live_r ? mem_q_r : '0);
  assign y_sum    = SAT_W'(s1_x_r) + SAT_W'(delayed);
  assign y_nxt    = fde_pkg::sat24(y_sum);
  assign prod_nxt = PROD_W'(delayed) * PROD_W'($signed({1'b0, gain_r}));

  // Stage two: round half up, add input and saturate.
  logic signed [PROD_W-1:0] rnd;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [SAT_W-1:0]  w_sum;

  assign rnd    = s2_prod_r + PROD_W'(fde_pkg::ROUND_HALF);
  assign scaled = $signed(rnd[PROD_W-1:fde_pkg::GAIN_FRAC]);
  assign w_sum  = SAT_W'(s2_x_r) + SAT_W'(scaled);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      wrapped_r  <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      if (accept) begin
        if (wp_r == LAST_C) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r     <= in_sample;
      s1_wp_r    <= wp_r;
      s1_live_r  <= rd_live;
      // The write leaving the last stage lands at this edge, after the read.
      s1_fwd_r   <= s3_valid_r && (s3_wp_r == rd_addr);
      s1_fwd_d_r <= s3_w_r;
    end
    s2_x_r    <= s1_x_r;
    s2_wp_r   <= s1_wp_r;
    s2_prod_r <= prod_nxt;
    s3_w_r    <= fde_pkg::sat24(w_sum);
    s3_wp_r   <= s2_wp_r;
  end

  // Output queue.
  logic signed [SW-1:0] ofifo [fde_pkg::FIFO_DEPTH];
  logic [FPW-1:0]       q_wr_r, q_rd_r;
  logic [CNT_W-1:0]     q_cnt_nxt;

  assign out_valid  = (q_cnt_r != '0);
  assign out_sample = ofifo[q_rd_r];
  assign pop        = out_valid && !out_stall;

  always_comb begin
    case ({s1_valid_r, pop})
      2'b10:   q_cnt_nxt = q_cnt_r + CNT_W'(1);
      2'b01:   q_cnt_nxt = q_cnt_r - CNT_W'(1);
      default: q_cnt_nxt = q_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (s1_valid_r) begin
        q_wr_r <= q_wr_r + FPW'(1);
      end
      if (pop) begin
        q_rd_r <= q_rd_r + FPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      ofifo[q_wr_r] <= y_nxt;
    end
  end

  // A result leaving stage one always finds room in the queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ((q_cnt_r < CNT_W'(fde_pkg::FIFO_DEPTH)) || pop))
    else $error("output queue overflow");

  // A forwarded value comes from a write that was leaving the pipeline.
  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_fwd_r) |-> $past(s3_valid_r))
    else $error("forwarding without a pending write");

  // Consecutive writes go to different entries.
  a_distinct_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s3_valid_r) |-> (s2_wp_r != s3_wp_r))
    else $error("two pending writes to one entry");

  // No sample is taken directly after a write of delay_ms, while the sample delay is being recomputed.
  a_dsamp_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == fde_pkg::CFG_DELAY_MS)) |=> !accept)
    else $error("sample taken before the delay was ready");

endmodule
`default_nettype wire

/* verif/tb_feedback_delay_echo.sv */
`default_nettype none
module tb_feedback_delay_echo;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SW          = fde_pkg::SAMPLE_W;
  localparam int          ECHO_DEPTH  = fde_pkg::DEF_AUDIO_FS * fde_pkg::DEF_MAX_DELAY_SECONDS;
  localparam longint      PEAK_POS    = 64'sd8388607;
  localparam longint      PEAK_NEG    = -64'sd8388608;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int          IDLE_PCT    = 38;
  localparam int          BEAT_TARGET = 1524;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic signed [SW-1:0]               in_sample = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [SW-1:0]               out_sample;
  logic                               cfg_we = 1'b0;
  logic [fde_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [fde_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  // Shadow of the block: delay memory, write pointer and the two registers.
  logic signed [SW-1:0]       echo_mem [ECHO_DEPTH];
  int unsigned                wr_ptr;
  int unsigned                delay_ms_now;
  int unsigned                gain_now;

  logic signed [SW-1:0]       sample_q [$];
  logic signed [SW-1:0]       echo_q [$];
  int unsigned                beats_queued = 0;
  int unsigned                beats_taken = 0;
  int unsigned                quiet_cycles = 0;
  int unsigned                errors = 0;
  bit                         calm = 1'b0;

  feedback_delay_echo i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic signed [SW-1:0] clip24(input longint v);
    if (v > PEAK_POS) begin
      return SW'(PEAK_POS);
    end else if (v < PEAK_NEG) begin
      return SW'(PEAK_NEG);
    end
    return SW'(v);
  endfunction

  // One sample through the echo: read the tap, form the output, write back the
  // input plus the scaled tap, then move the write pointer on.
  function automatic logic signed [SW-1:0] echo_step(input logic signed [SW-1:0] x);
    int unsigned                lag;
    int unsigned                tap;
    int unsigned                g;
    logic signed [SW-1:0]       delayed;
    longint                     scaled;
    lag = delay_ms_now * fde_pkg::DEF_AUDIO_FS / fde_pkg::MS_PER_SECOND;
    if (lag > ECHO_DEPTH) begin
      lag = ECHO_DEPTH;
    end
    tap = (wr_ptr + ECHO_DEPTH - lag) % ECHO_DEPTH;
    delayed = echo_mem[tap];
    g = (gain_now > fde_pkg::GAIN_ONE) ? fde_pkg::GAIN_ONE : gain_now;
    // Round half up, then floor: an arithmetic shift of the signed product.
    scaled = (longint'(delayed) * longint'(g) + longint'(fde_pkg::ROUND_HALF))
             >>> fde_pkg::GAIN_FRAC;
    echo_mem[wr_ptr] = clip24(longint'(x) + scaled);
    wr_ptr = (wr_ptr + 1) % ECHO_DEPTH;
    return clip24(longint'(x) + longint'(delayed));
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return SW'(PEAK_POS) - SW'($urandom_range(255));
      1: return SW'(PEAK_NEG) + SW'($urandom_range(255));
      2, 3: return SW'($urandom_range(4194304, 8388607));
      4, 5: return -SW'($urandom_range(4194304, 8388608));
      6, 7: return SW'($urandom);
      default: return SW'($urandom_range(2047)) - SW'(1024);
    endcase
  endfunction

  task automatic write_reg(input fde_pkg::cfg_reg_t idx,
                           input logic [fde_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == fde_pkg::CFG_DELAY_MS) begin
      delay_ms_now = value[fde_pkg::DMS_W-1:0];
    end else begin
      gain_now = value[fde_pkg::GAIN_W-1:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sample(input logic signed [SW-1:0] s);
    sample_q.push_back(s);
    beats_queued++;
  endtask

  // Sampled on the falling edge so that the counts of the last rising edge
  // have settled.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (beats_taken != beats_queued || echo_q.size() != 0);
  endtask

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        echo_q.push_back(echo_step(in_sample));
        beats_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid  <= 1'b1;
          in_sample <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    logic signed [SW-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (echo_q.size() == 0) begin
        $error("out_sample: beat with nothing expected, got %0d", out_sample);
        errors++;
      end else begin
        want = echo_q.pop_front();
        if (out_sample !== want) begin
          $error("out_sample: expected %0d, got %0d", want, out_sample);
          errors++;
        end
      end
    end
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned                   phase;
    int unsigned                   n;
    int unsigned                   dms;
    logic [fde_pkg::GAIN_W-1:0]    g;
    logic signed [SW-1:0]          corner [6];
    for (int i = 0; i < ECHO_DEPTH; i++) begin
      echo_mem[i] = '0;
    end
    wr_ptr       = 0;
    delay_ms_now = fde_pkg::DELAY_MS_RESET;
    gain_now     = fde_pkg::GAIN_RESET;
    corner = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF, 24'sh555555, 24'shAAAAAA};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Corners of the sample range under the reset settings, then with zero
    // delay and a gain above one, then an over-long delay with every data bit
    // set and no feedback, then the longest legal delay at unity gain.
    @(negedge clk);
    foreach (corner[i]) queue_sample(corner[i]);
    wait_drained();
    write_reg(fde_pkg::CFG_DELAY_MS, '0);
    write_reg(fde_pkg::CFG_FEEDBACK_GAIN, 17'h1FFFF);
    @(negedge clk);
    foreach (corner[i]) queue_sample(corner[5 - i]);
    wait_drained();
    write_reg(fde_pkg::CFG_DELAY_MS, 17'h1FFFF);
    write_reg(fde_pkg::CFG_FEEDBACK_GAIN, '0);
    @(negedge clk);
    foreach (corner[i]) queue_sample(corner[i]);
    wait_drained();
    write_reg(fde_pkg::CFG_DELAY_MS, fde_pkg::CFG_DATA_W'(2000));
    write_reg(fde_pkg::CFG_FEEDBACK_GAIN, fde_pkg::CFG_DATA_W'(fde_pkg::GAIN_ONE));
    @(negedge clk);
    foreach (corner[i]) queue_sample(-corner[i]);
    wait_drained();

    // Short delays dominate so that echoes and feedback build up within a
    // phase; the memory carries over from one phase to the next.
    phase = 0;
    while (beats_queued < BEAT_TARGET) begin
      if (phase == 0 || $urandom_range(3) != 0) begin
        case ($urandom_range(19))
          0: dms = 0;
          1: dms = 2047;
          2: dms = 2000;
          3: dms = $urandom_range(2047);
          default: dms = $urandom_range(1, 6);
        endcase
        write_reg(fde_pkg::CFG_DELAY_MS, {6'($urandom), fde_pkg::DMS_W'(dms)});
      end
      if (phase == 0 || $urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0: g = '0;
          1: g = fde_pkg::GAIN_W'(fde_pkg::GAIN_ONE);
          2: g = '1;
          3: g = fde_pkg::GAIN_W'($urandom);
          default: g = fde_pkg::GAIN_W'($urandom_range(40000, fde_pkg::GAIN_ONE));
        endcase
        write_reg(fde_pkg::CFG_FEEDBACK_GAIN, fde_pkg::CFG_DATA_W'(g));
      end
      calm = (phase == 3);
      n = calm ? 300 : $urandom_range(80, 250);
      @(negedge clk);
      repeat (n) queue_sample(pick_sample());
      wait_drained();
      calm = 1'b0;
      phase++;
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
hdl/fde_pkg.sv
hdl/feedback_delay_echo.sv
verif/tb_feedback_delay_echo.sv
